>>> sv/epwm_pkg.sv
package epwm_pkg;

	// Counter width and the widths that follow from it
	localparam int COUNT_WIDTH = 16;
	localparam int CMP_W       = COUNT_WIDTH + 1;
	localparam int OP_W        = 2;
	localparam int VAL_W       = 17;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = COUNT_WIDTH;

	// Stream packing, rounded up to whole bytes
	localparam int IN_FIELDS_W  = OP_W + VAL_W;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 2 + COUNT_WIDTH + CMP_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Compare saturation limit and duty scaling
	localparam longint COMPARE_MAX  = 64'd1 << COUNT_WIDTH;
	localparam longint PERCENT_FULL = 100;
	localparam int     PCT_W        = 7;
	localparam int     PROD_W       = PCT_W + CMP_W;

	// Reciprocal of the percent divisor: q = (x * RECIP) >> RECIP_SH, exact for x < 2**PROD_W
	localparam int     RECIP_SH = PROD_W + PCT_W;
	localparam int     RECIP_W  = RECIP_SH - 6;
	localparam longint RECIP    = ((64'd1 << RECIP_SH) + PERCENT_FULL - 1) / PERCENT_FULL;

	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 2'd0,
		OP_RAW   = 2'd1,
		OP_PCT   = 2'd2,
		OP_FORCE = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PRESCALER   = 3'd0,
		CFG_AUTO_RELOAD = 3'd1,
		CFG_PRELOAD     = 3'd2,
		CFG_OUT_ENABLE  = 3'd3,
		CFG_OUT_INVERT  = 3'd4,
		CFG_CNT_ENABLE  = 3'd5
	} cfg_idx_t;

	// Decoded item handed from the scaling pipe to the timer state
	typedef struct packed {
		op_t              op;
		logic [CMP_W-1:0] cmp;
	} item_t;

endpackage

>>> sv/epwm_scale.sv
module epwm_scale (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [epwm_pkg::COUNT_WIDTH-1:0] auto_reload,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  epwm_pkg::op_t                in_op,
	input  logic [epwm_pkg::VAL_W-1:0]   in_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output epwm_pkg::item_t              out_item
);

	localparam int FULL_W = epwm_pkg::PROD_W + epwm_pkg::RECIP_W;

	logic                          v_s1, v_s2, v_s3;
	logic                          rdy1, rdy2, rdy3;
	epwm_pkg::op_t                 op_s1, op_s2;
	logic [epwm_pkg::VAL_W-1:0]    val_s1;
	logic [epwm_pkg::CMP_W-1:0]    raw_s2;
	logic [epwm_pkg::PROD_W-1:0]   prod_s2;
	epwm_pkg::item_t               item_s3;

	logic [epwm_pkg::PCT_W-1:0]    pct;
	logic [epwm_pkg::CMP_W-1:0]    period;
	logic [epwm_pkg::CMP_W-1:0]    raw_sat;
	logic [epwm_pkg::PROD_W-1:0]   prod;
	logic [FULL_W-1:0]             full;
	logic [epwm_pkg::CMP_W-1:0]    quot;

	// Each stage moves when the next one is empty or moving
	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	// Stage 1: saturate raw compare, clamp percent and scale by the period
	always_comb begin
		raw_sat = (val_s1 > epwm_pkg::VAL_W'(epwm_pkg::COMPARE_MAX)) ?
			epwm_pkg::CMP_W'(epwm_pkg::COMPARE_MAX) : epwm_pkg::CMP_W'(val_s1);
		pct     = (val_s1 > epwm_pkg::VAL_W'(epwm_pkg::PERCENT_FULL)) ?
			epwm_pkg::PCT_W'(epwm_pkg::PERCENT_FULL) : val_s1[epwm_pkg::PCT_W-1:0];
		period  = epwm_pkg::CMP_W'(auto_reload) + 1'b1;
		prod    = epwm_pkg::PROD_W'(pct) * epwm_pkg::PROD_W'(period);
	end

	// Stage 2: divide the scaled percent by the reciprocal multiply
	always_comb begin
		full = FULL_W'(prod_s2) * FULL_W'(epwm_pkg::RECIP);
		quot = full[epwm_pkg::RECIP_SH +: epwm_pkg::CMP_W];
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			op_s1  <= in_op;
			val_s1 <= in_value;
		end
		if (rdy2) begin
			op_s2   <= op_s1;
			raw_s2  <= raw_sat;
			prod_s2 <= prod;
		end
		if (rdy3) begin
			item_s3.op  <= op_s2;
			item_s3.cmp <= (op_s2 == epwm_pkg::OP_PCT) ? quot : raw_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_item  = item_s3;

endmodule

>>> sv/edge_aligned_pwm_timer_top.sv
// Edge-aligned up-counting PWM timer. Each input transfer carries one operation: a tick,
// a raw compare write, a duty-percent write or a forced update; each gives exactly one
// result transfer with the pin level, the update flag, the main count and the live compare.
// Items stream at one per clock: a transfer is taken every cycle while the result side
// keeps up. The four registers on the way from an input transfer to its result are the
// input stage, a stage after the saturate and percent multiply, a stage after the
// reciprocal divide, and the counter state register that also holds the result.
// Configuration writes take effect at the next edge and are meant for an idle block.
module edge_aligned_pwm_timer_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// operation [1:0], value [18:2]
	input  logic [epwm_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// pwm_level [0], update_event [1], count_value [17:2], active_compare [34:18]
	output logic [epwm_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                               cfg_we,
	input  logic [epwm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [epwm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	localparam int CW = epwm_pkg::COUNT_WIDTH;

	// Configuration registers
	logic [CW-1:0] psc_cfg_q, arr_q;
	logic          pre_q, oen_q, inv_q, cen_q;

	// Timer state and result flags
	logic [CW-1:0]              psc_q, cnt_q, psc_d, cnt_d;
	logic [epwm_pkg::CMP_W-1:0] shad_q, live_q, shad_d, live_d;
	logic                       upd_q, lvl_q, upd_d, lvl_d;
	logic                       out_valid_q;

	logic            sc_valid, ready_out, fire;
	epwm_pkg::item_t item;

	// Write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psc_cfg_q <= '0;
			arr_q     <= '1;
			pre_q     <= 1'b0;
			oen_q     <= 1'b0;
			inv_q     <= 1'b0;
			cen_q     <= 1'b0;
		end else if (cfg_we) begin
			case (epwm_pkg::cfg_idx_t'(cfg_index))
				epwm_pkg::CFG_PRESCALER:   psc_cfg_q <= cfg_wdata[CW-1:0];
				epwm_pkg::CFG_AUTO_RELOAD: arr_q     <= cfg_wdata[CW-1:0];
				epwm_pkg::CFG_PRELOAD:     pre_q     <= cfg_wdata[0];
				epwm_pkg::CFG_OUT_ENABLE:  oen_q     <= cfg_wdata[0];
				epwm_pkg::CFG_OUT_INVERT:  inv_q     <= cfg_wdata[0];
				epwm_pkg::CFG_CNT_ENABLE:  cen_q     <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	epwm_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.auto_reload (arr_q),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_op       (epwm_pkg::op_t'(s_tdata[epwm_pkg::OP_W-1:0])),
		.in_value    (s_tdata[epwm_pkg::OP_W +: epwm_pkg::VAL_W]),
		.out_valid   (sc_valid),
		.out_ready   (ready_out),
		.out_item    (item)
	);

	// Take a scaled item whenever the result register is free or being drained
	assign ready_out = !out_valid_q || m_tready;
	assign fire      = sc_valid && ready_out;

	// Advance the counters, apply compare writes and derive the pin level
	always_comb begin
		psc_d  = psc_q;
		cnt_d  = cnt_q;
		shad_d = shad_q;
		live_d = live_q;
		upd_d  = 1'b0;
		case (item.op)
			epwm_pkg::OP_TICK: begin
				if (cen_q) begin
					if (psc_q >= psc_cfg_q) begin
						psc_d = '0;
						if (cnt_q >= arr_q) begin
							cnt_d = '0;
							upd_d = 1'b1;
						end else begin
							cnt_d = cnt_q + 1'b1;
						end
					end else begin
						psc_d = psc_q + 1'b1;
					end
				end
			end
			epwm_pkg::OP_RAW, epwm_pkg::OP_PCT: begin
				shad_d = item.cmp;
				if (!pre_q) live_d = item.cmp;
			end
			epwm_pkg::OP_FORCE: begin
				psc_d = '0;
				cnt_d = '0;
				upd_d = 1'b1;
			end
			default: ;
		endcase
		if (upd_d) live_d = shad_q;
		lvl_d = ((epwm_pkg::CMP_W'(cnt_d) < live_d) ^ inv_q) & oen_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psc_q       <= '0;
			cnt_q       <= '0;
			shad_q      <= '0;
			live_q      <= '0;
			upd_q       <= 1'b0;
			lvl_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				psc_q  <= psc_d;
				cnt_q  <= cnt_d;
				shad_q <= shad_d;
				live_q <= live_d;
				upd_q  <= upd_d;
				lvl_q  <= lvl_d;
			end
			if (fire) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = epwm_pkg::OUT_DATA_W'({live_q, cnt_q, upd_q, lvl_q});

	// A forced update always restarts the count and flags the event
	a_force_restart: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.op == epwm_pkg::OP_FORCE |=> upd_q && cnt_q == '0)
		else $error("forced update did not restart the counter");

	// An update result shows a zero count and the shadow compare latched
	a_update_latch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && upd_q |-> cnt_q == '0 && live_q == shad_q)
		else $error("update event without wrap or compare latch");

	// With counting off a tick leaves the count alone and raises no event
	a_tick_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.op == epwm_pkg::OP_TICK && !cen_q |=> cnt_q == $past(cnt_q) && !upd_q)
		else $error("disabled counter moved on a tick");

	// Without preload a compare write goes live at once
	a_direct_write: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (item.op == epwm_pkg::OP_RAW || item.op == epwm_pkg::OP_PCT) && !pre_q
		|=> live_q == $past(item.cmp))
		else $error("direct compare write not applied");

endmodule
